// File: src/bmp_stream_decoder_macros.svh
// assertion macros for the bmp stream decoder
// no dependencies; included by modules that carry concurrent checks
`ifndef BMP_STREAM_DECODER_MACROS_SVH
`define BMP_STREAM_DECODER_MACROS_SVH

// same-cycle implication
`define BSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmp_stream_decoder check failed");

// next-cycle implication
`define BSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmp_stream_decoder check failed");

`endif

// File: src/bsd_pkg.sv
// shared constants for the bmp stream decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bsd_pkg;

  localparam int unsigned MaxDim    = 4096;
  localparam int unsigned HdrLen    = 54;
  localparam int unsigned PalBytes  = 1024;
  localparam int unsigned PalDataEnd = HdrLen + PalBytes;

  localparam logic [7:0] MagicB = 8'h42;
  localparam logic [7:0] MagicM = 8'h4D;

  // parse phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_PALETTE = 3'd1;
  localparam logic [2:0] PH_SKIP    = 3'd2;
  localparam logic [2:0] PH_PIXELS  = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_HDR_OK  = 2'd1,
    KIND_HDR_REJ = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MAGIC    = 3'd1,
    ST_COMPRESS = 3'd2,
    ST_TOPDOWN  = 3'd3,
    ST_PLANES   = 3'd4,
    ST_DEPTH    = 3'd5,
    ST_SIZE     = 3'd6,
    ST_OFFSET   = 3'd7
  } status_e;

  localparam logic [5:0] PosOffset = 6'd13;
  localparam logic [5:0] PosWidth  = 6'd21;
  localparam logic [5:0] PosHeight = 6'd25;
  localparam logic [5:0] PosPlanes = 6'd27;
  localparam logic [5:0] PosDepth  = 6'd29;
  localparam logic [5:0] PosComp   = 6'd33;
  localparam logic [5:0] PosLast   = 6'(HdrLen - 1);

endpackage

`default_nettype wire

// File: src/bmp_stream_decoder.sv
// The result of an accepted byte is registered and shown on the master side in the cycle after it is accepted.
// Throughput: one byte per cycle; a byte waits only while a result is held unread.
// Header bytes other than the last, palette bytes, skipped bytes and row padding give no result.
// Palette reads use a 256x24 memory with a registered read port.
// Reset: rst_ni asynchronous active low; parsing restarts at byte 0, limit_x = 4096.
// Depends on bsd_pkg and bmp_stream_decoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "bmp_stream_decoder_macros.svh"

module bmp_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i,   // limit_x
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // file_byte [7:0]
  input  wire logic        s_axis_tuser,  // start_flag
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status [2:0], pixel_word [34:3], row [46:35], column [58:47],
  // image_width [71:59], image_height [84:72], zero [87:85]
  output logic [87:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,  // kind
  output logic             m_axis_tlast   // last
);

  // configuration
  logic [12:0] limit_q;

  // control state
  logic [2:0]  phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [13:0] rbc_q, rbc_d;
  logic [12:0] frc_q, frc_d;
  logic [1:0]  mod3_q, mod3_d;
  logic [11:0] colcnt_q, colcnt_d;
  logic        out_valid_q, out_valid_d;

  // header payload
  logic [31:0] hs_q, hs_d;
  logic        magic_q, magic_d;
  logic [31:0] pix_off_q, pix_off_d;
  logic [31:0] raw_w_q, raw_w_d;
  logic [31:0] raw_h_q, raw_h_d;
  logic [15:0] raw_planes_q, raw_planes_d;
  logic [15:0] raw_depth_q, raw_depth_d;
  logic [31:0] raw_comp_q, raw_comp_d;
  logic [12:0] width_q, width_d;
  logic [12:0] height_q, height_d;
  logic        is8_q, is8_d;
  logic [13:0] data_len_q, data_len_d;
  logic [13:0] row_len_q, row_len_d;
  logic [15:0] pa_q, pa_d;

  // result register
  bsd_pkg::kind_e   o_kind_q, o_kind_d;
  bsd_pkg::status_e o_status_q, o_status_d;
  logic [11:0] o_row_q, o_row_d;
  logic [11:0] o_col_q, o_col_d;
  logic [12:0] o_w_q, o_w_d;
  logic [12:0] o_h_q, o_h_d;
  logic        o_last_q, o_last_d;
  logic        o_pal_q, o_pal_d;
  logic [23:0] o_rgb_q, o_rgb_d;

  // palette memory
  logic [23:0] pal_mem [256];
  logic [23:0] pal_rd_q;
  logic        pal_we;
  logic [7:0]  pal_waddr;

  // per-transaction working signals
  logic        s_accept;
  logic        start;
  logic [7:0]  b;
  logic [2:0]  cur_phase;
  logic [31:0] cur_pos;
  logic [13:0] cur_rbc;
  logic [12:0] cur_frc;
  logic [1:0]  cur_mod3;
  logic [11:0] cur_colcnt;
  logic [31:0] hs_new;
  logic [9:0]  pal_idx;
  logic        pix_active;
  logic        have;
  logic [11:0] col;
  logic [12:0] lim;
  logic [12:0] row_full;
  logic [13:0] rbc_inc;
  logic [12:0] frc_inc;
  bsd_pkg::status_e hdr_st;
  logic [12:0] sat_w, sat_h;
  logic [13:0] w3;
  logic [13:0] dlen_new;
  logic [13:0] rlen_sum;
  logic [10:0] data_end;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign start         = s_axis_tuser;
  assign b             = s_axis_tdata[7:0];

  assign cur_phase  = start ? bsd_pkg::PH_HEADER : phase_q;
  assign cur_pos    = start ? 32'd0 : pos_q;
  assign cur_rbc    = start ? 14'd0 : rbc_q;
  assign cur_frc    = start ? 13'd0 : frc_q;
  assign cur_mod3   = start ? 2'd0 : mod3_q;
  assign cur_colcnt = start ? 12'd0 : colcnt_q;

  assign hs_new   = {b, hs_q[31:8]};
  assign pal_idx  = 10'(cur_pos[10:0] - 11'(bsd_pkg::HdrLen));
  assign rbc_inc  = cur_rbc + 14'd1;
  assign frc_inc  = cur_frc + 13'd1;
  assign lim      = (limit_q < width_q) ? limit_q : width_q;
  assign row_full = height_q - 13'd1 - cur_frc;

  assign sat_w    = (raw_w_q > 32'd8191) ? 13'h1FFF : raw_w_q[12:0];
  assign sat_h    = (raw_h_q > 32'd8191) ? 13'h1FFF : raw_h_q[12:0];
  assign w3       = {1'b0, raw_w_q[12:0]} + {raw_w_q[12:0], 1'b0};
  assign dlen_new = (raw_depth_q == 16'd8) ? {1'b0, raw_w_q[12:0]} : w3;
  assign rlen_sum = (dlen_new + 14'd3) & ~14'd3;
  assign data_end = (raw_depth_q == 16'd8) ? 11'(bsd_pkg::PalDataEnd)
                                           : 11'(bsd_pkg::HdrLen);

  assign pix_active = (cur_phase == bsd_pkg::PH_PIXELS) ||
                      ((cur_phase == bsd_pkg::PH_SKIP) && (cur_pos == pix_off_q));

  // header checks in priority order
  always_comb begin
    priority if (!magic_q) begin
      hdr_st = bsd_pkg::ST_MAGIC;
    end else if (raw_comp_q != 32'd0) begin
      hdr_st = bsd_pkg::ST_COMPRESS;
    end else if (raw_h_q[31]) begin
      hdr_st = bsd_pkg::ST_TOPDOWN;
    end else if (raw_planes_q != 16'd1) begin
      hdr_st = bsd_pkg::ST_PLANES;
    end else if (raw_depth_q != 16'd8 && raw_depth_q != 16'd24) begin
      hdr_st = bsd_pkg::ST_DEPTH;
    end else if (raw_w_q > 32'(bsd_pkg::MaxDim) || raw_h_q > 32'(bsd_pkg::MaxDim)) begin
      hdr_st = bsd_pkg::ST_SIZE;
    end else if (pix_off_q < {21'd0, data_end}) begin
      hdr_st = bsd_pkg::ST_OFFSET;
    end else begin
      hdr_st = bsd_pkg::ST_OK;
    end
  end

  // pixel extraction
  always_comb begin
    have = 1'b0;
    col  = 12'd0;
    if (is8_q) begin
      if (cur_rbc < data_len_q) begin
        have = 1'b1;
        col  = cur_rbc[11:0];
      end
    end else if (cur_rbc < data_len_q && cur_mod3 == 2'd2) begin
      have = 1'b1;
      col  = cur_colcnt;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    rbc_d        = rbc_q;
    frc_d        = frc_q;
    mod3_d       = mod3_q;
    colcnt_d     = colcnt_q;
    hs_d         = hs_q;
    magic_d      = magic_q;
    pix_off_d    = pix_off_q;
    raw_w_d      = raw_w_q;
    raw_h_d      = raw_h_q;
    raw_planes_d = raw_planes_q;
    raw_depth_d  = raw_depth_q;
    raw_comp_d   = raw_comp_q;
    width_d      = width_q;
    height_d     = height_q;
    is8_d        = is8_q;
    data_len_d   = data_len_q;
    row_len_d    = row_len_q;
    pa_d         = pa_q;
    pal_we       = 1'b0;
    pal_waddr    = pal_idx[9:2];
    o_kind_d     = o_kind_q;
    o_status_d   = o_status_q;
    o_row_d      = o_row_q;
    o_col_d      = o_col_q;
    o_w_d        = o_w_q;
    o_h_d        = o_h_q;
    o_last_d     = o_last_q;
    o_pal_d      = o_pal_q;
    o_rgb_d      = o_rgb_q;
    out_valid_d  = out_valid_q && !m_axis_tready;

    if (s_accept) begin
      out_valid_d = 1'b0;
      pos_d       = cur_pos + 32'd1;
      phase_d     = cur_phase;
      rbc_d       = cur_rbc;
      frc_d       = cur_frc;
      mod3_d      = cur_mod3;
      colcnt_d    = cur_colcnt;

      unique case (cur_phase)
        bsd_pkg::PH_HEADER: begin
          hs_d = hs_new;
          if (cur_pos == 32'd0) begin
            magic_d = (b == bsd_pkg::MagicB);
          end else if (cur_pos == 32'd1) begin
            magic_d = magic_q && (b == bsd_pkg::MagicM);
          end
          if (cur_pos[5:0] == bsd_pkg::PosOffset) pix_off_d    = hs_new;
          if (cur_pos[5:0] == bsd_pkg::PosWidth)  raw_w_d      = hs_new;
          if (cur_pos[5:0] == bsd_pkg::PosHeight) raw_h_d      = hs_new;
          if (cur_pos[5:0] == bsd_pkg::PosPlanes) raw_planes_d = hs_new[31:16];
          if (cur_pos[5:0] == bsd_pkg::PosDepth)  raw_depth_d  = hs_new[31:16];
          if (cur_pos[5:0] == bsd_pkg::PosComp)   raw_comp_d   = hs_new;
          if (cur_pos[5:0] == bsd_pkg::PosLast) begin
            out_valid_d = 1'b1;
            o_kind_d    = (hdr_st == bsd_pkg::ST_OK) ? bsd_pkg::KIND_HDR_OK
                                                     : bsd_pkg::KIND_HDR_REJ;
            o_status_d  = hdr_st;
            o_row_d     = 12'd0;
            o_col_d     = 12'd0;
            o_w_d       = sat_w;
            o_h_d       = sat_h;
            o_last_d    = 1'b0;
            o_pal_d     = 1'b0;
            o_rgb_d     = 24'd0;
            if (hdr_st != bsd_pkg::ST_OK) begin
              phase_d = bsd_pkg::PH_DONE;
            end else begin
              width_d    = raw_w_q[12:0];
              height_d   = raw_h_q[12:0];
              is8_d      = (raw_depth_q == 16'd8);
              data_len_d = dlen_new;
              row_len_d  = rlen_sum;
              if (raw_w_q[12:0] == 13'd0 || raw_h_q[12:0] == 13'd0) begin
                phase_d = bsd_pkg::PH_DONE;
              end else if (raw_depth_q == 16'd8) begin
                phase_d = bsd_pkg::PH_PALETTE;
              end else begin
                phase_d = bsd_pkg::PH_SKIP;
              end
            end
          end
        end
        bsd_pkg::PH_PALETTE: begin
          hs_d   = hs_new;
          pal_we = (pal_idx[1:0] == 2'd3);
          if (pal_idx == 10'(bsd_pkg::PalBytes - 1)) phase_d = bsd_pkg::PH_SKIP;
        end
        bsd_pkg::PH_SKIP, bsd_pkg::PH_PIXELS: begin
          if (pix_active) begin
            phase_d = bsd_pkg::PH_PIXELS;
            if (!is8_q && cur_rbc < data_len_q) begin
              unique case (cur_mod3)
                2'd0: begin
                  pa_d   = {8'd0, b};
                  mod3_d = 2'd1;
                end
                2'd1: begin
                  pa_d   = {b, pa_q[7:0]};
                  mod3_d = 2'd2;
                end
                default: begin
                  mod3_d   = 2'd0;
                  colcnt_d = cur_colcnt + 12'd1;
                end
              endcase
            end
            if (have && {1'b0, col} < lim) begin
              out_valid_d = 1'b1;
              o_kind_d    = bsd_pkg::KIND_PIXEL;
              o_status_d  = bsd_pkg::ST_OK;
              o_row_d     = row_full[11:0];
              o_col_d     = col;
              o_w_d       = 13'd0;
              o_h_d       = 13'd0;
              o_last_d    = (row_full == 13'd0) && ({1'b0, col} == lim - 13'd1);
              o_pal_d     = is8_q;
              o_rgb_d     = {pa_q[7:0], pa_q[15:8], b};
            end
            if (rbc_inc >= row_len_q) begin
              rbc_d    = 14'd0;
              mod3_d   = 2'd0;
              colcnt_d = 12'd0;
              frc_d    = frc_inc;
              if (frc_inc >= height_q) phase_d = bsd_pkg::PH_DONE;
            end else begin
              rbc_d = rbc_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= 13'(bsd_pkg::MaxDim);
      phase_q     <= bsd_pkg::PH_HEADER;
      pos_q       <= 32'd0;
      rbc_q       <= 14'd0;
      frc_q       <= 13'd0;
      mod3_q      <= 2'd0;
      colcnt_q    <= 12'd0;
      out_valid_q <= 1'b0;
      width_q     <= 13'd0;
      height_q    <= 13'd0;
      is8_q       <= 1'b0;
      data_len_q  <= 14'd0;
      row_len_q   <= 14'd0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      rbc_q       <= rbc_d;
      frc_q       <= frc_d;
      mod3_q      <= mod3_d;
      colcnt_q    <= colcnt_d;
      out_valid_q <= out_valid_d;
      width_q     <= width_d;
      height_q    <= height_d;
      is8_q       <= is8_d;
      data_len_q  <= data_len_d;
      row_len_q   <= row_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hs_q         <= hs_d;
    magic_q      <= magic_d;
    pix_off_q    <= pix_off_d;
    raw_w_q      <= raw_w_d;
    raw_h_q      <= raw_h_d;
    raw_planes_q <= raw_planes_d;
    raw_depth_q  <= raw_depth_d;
    raw_comp_q   <= raw_comp_d;
    pa_q         <= pa_d;
    o_kind_q     <= o_kind_d;
    o_status_q   <= o_status_d;
    o_row_q      <= o_row_d;
    o_col_q      <= o_col_d;
    o_w_q        <= o_w_d;
    o_h_q        <= o_h_d;
    o_last_q     <= o_last_d;
    o_pal_q      <= o_pal_d;
    o_rgb_q      <= o_rgb_d;
  end

  // palette memory, registered read at the incoming byte
  always_ff @(posedge clk_i) begin
    if (s_accept && pal_we) pal_mem[pal_waddr] <= hs_q[31:8];
    if (s_accept) pal_rd_q <= pal_mem[b];
  end

  logic [31:0] pixel_word;
  always_comb begin
    if (o_kind_q != bsd_pkg::KIND_PIXEL) begin
      pixel_word = 32'd0;
    end else if (o_pal_q) begin
      pixel_word = {8'hFF, pal_rd_q[7:0], pal_rd_q[15:8], pal_rd_q[23:16]};
    end else begin
      pixel_word = {8'hFF, o_rgb_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {3'd0, o_h_q, o_w_q, o_col_q, o_row_q, pixel_word, o_status_q};

  `BSD_ASSERT_NXT(a_done_silent, clk_i, rst_ni,
    s_accept && !start && phase_q == bsd_pkg::PH_DONE, !m_axis_tvalid)
  `BSD_ASSERT_IMP(a_row_count_bound, clk_i, rst_ni,
    phase_q == bsd_pkg::PH_PIXELS, rbc_q < row_len_q && frc_q < height_q)
  `BSD_ASSERT_IMP(a_palette_depth, clk_i, rst_ni,
    phase_q == bsd_pkg::PH_PALETTE, is8_q)
  `BSD_ASSERT_IMP(a_pixel_in_bounds, clk_i, rst_ni,
    out_valid_q && o_kind_q == bsd_pkg::KIND_PIXEL,
    {1'b0, o_col_q} < width_q && {1'b0, o_row_q} < height_q)

endmodule

`default_nettype wire
